// ===== hdl/pahb_pkg.sv =====
// Package: payload types, register indices and the coefficient tables for the half-band filter.
package pahb_pkg;

    localparam int SW = 24;
    localparam int CW = 18;
    localparam int NSTG = 6;

    localparam logic [1:0] RATE_SAME = 2'd0;
    localparam logic [1:0] RATE_DECIM = 2'd1;
    localparam logic [1:0] RATE_INTERP = 2'd2;

    localparam logic [1:0] CFG_RATE = 2'd0;
    localparam logic [1:0] CFG_STEEP = 2'd1;
    localparam logic [1:0] CFG_STAGES = 2'd2;

    typedef struct packed {
        logic signed [SW-1:0] left_sample;
        logic signed [SW-1:0] right_sample;
        logic                 block_last;
    } in_item_t;

    typedef struct packed {
        logic signed [SW-1:0] left_out;
        logic signed [SW-1:0] right_out;
        logic                 run_last;
    } out_item_t;

    // Per-lane control sent from the sequencer to each lane.
    typedef struct packed {
        logic       start;
        logic [2:0] stage;
        logic       zero_in;
        logic [CW-1:0] coef;
    } lane_ctl_t;

    // Coefficient lookup: path b selects the B table, n is stage count 1..6, s the stage.
    function automatic logic [CW-1:0] coef_lookup(input logic b, input logic steep,
                                                  input logic [2:0] n, input logic [2:0] s);
        logic [CW-1:0] c;
        c = '0;
        case ({b, steep, n, s})
            8'b0_0_001_000: c = 18'd61989;
            8'b0_0_010_000: c = 18'd20937;  8'b0_0_010_001: c = 18'd142961;
            8'b0_0_011_000: c = 18'd15807;  8'b0_0_011_001: c = 18'd108158;
            8'b0_0_011_010: c = 18'd202563;
            8'b0_0_100_000: c = 18'd9393;   8'b0_0_100_001: c = 18'd71314;
            8'b0_0_100_010: c = 18'd149961; 8'b0_0_100_011: c = 18'd216826;
            8'b0_0_101_000: c = 18'd6205;   8'b0_0_101_001: c = 18'd49780;
            8'b0_0_101_010: c = 18'd113134; 8'b0_0_101_011: c = 18'd173854;
            8'b0_0_101_100: c = 18'd225448;
            8'b0_0_110_000: c = 18'd4397;   8'b0_0_110_001: c = 18'd36444;
            8'b0_0_110_010: c = 18'd87163;  8'b0_0_110_011: c = 18'd140945;
            8'b0_0_110_100: c = 18'd189116; 8'b0_0_110_101: c = 18'd231260;
            8'b0_1_001_000: c = 18'd61989;
            8'b0_1_010_000: c = 18'd31649;  8'b0_1_010_001: c = 18'd173854;
            8'b0_1_011_000: c = 18'd33329;  8'b0_1_011_001: c = 18'd171134;
            8'b0_1_011_010: c = 18'd240568;
            8'b0_1_100_000: c = 18'd20215;  8'b0_1_100_001: c = 18'd126372;
            8'b0_1_100_010: c = 18'd208882; 8'b0_1_100_011: c = 18'd246743;
            8'b0_1_101_000: c = 18'd13489;  8'b0_1_101_001: c = 18'd94316;
            8'b0_1_101_010: c = 18'd176304; 8'b0_1_101_011: c = 18'd225205;
            8'b0_1_101_100: c = 18'd250091;
            8'b0_1_110_000: c = 18'd9616;   8'b0_1_110_001: c = 18'd71993;
            8'b0_1_110_010: c = 18'd147089; 8'b0_1_110_011: c = 18'd201783;
            8'b0_1_110_100: c = 18'd233901; 8'b0_1_110_101: c = 18'd252207;
            8'b1_0_001_000: c = 18'd187313;
            8'b1_0_010_000: c = 18'd74404;  8'b1_0_010_001: c = 18'd218736;
            8'b1_0_011_000: c = 18'd56616;  8'b1_0_011_001: c = 18'd158429;
            8'b1_0_011_010: c = 18'd242191;
            8'b1_0_100_000: c = 18'd35151;  8'b1_0_100_001: c = 18'd111234;
            8'b1_0_100_010: c = 18'd185150; 8'b1_0_100_011: c = 18'd246809;
            8'b1_0_101_000: c = 18'd23741;  8'b1_0_101_001: c = 18'd80703;
            8'b1_0_101_010: c = 18'd144599; 8'b1_0_101_011: c = 18'd200596;
            8'b1_0_101_100: c = 18'd249686;
            8'b1_0_110_000: c = 18'd17043;  8'b1_0_110_001: c = 18'd60540;
            8'b1_0_110_010: c = 18'd114424; 8'b1_0_110_011: c = 18'd165927;
            8'b1_0_110_100: c = 18'd210706; 8'b1_0_110_101: c = 18'd251650;
            8'b1_1_001_000: c = 18'd187313;
            8'b1_1_010_000: c = 18'd102331; 8'b1_1_010_001: c = 18'd233514;
            8'b1_1_011_000: c = 18'd105006; 8'b1_1_011_001: c = 18'd215067;
            8'b1_1_011_010: c = 18'd255934;
            8'b1_1_100_000: c = 18'd69722;  8'b1_1_100_001: c = 18'd174353;
            8'b1_1_100_010: c = 18'd231762; 8'b1_1_100_011: c = 18'd257427;
            8'b1_1_101_000: c = 18'd48816;  8'b1_1_101_001: c = 18'd138924;
            8'b1_1_101_010: c = 18'd204741; 8'b1_1_101_011: c = 18'd239647;
            8'b1_1_101_100: c = 18'd258336;
            8'b1_1_110_000: c = 18'd35795;  8'b1_1_110_001: c = 18'd110923;
            8'b1_1_110_010: c = 18'd177613; 8'b1_1_110_011: c = 18'd220172;
            8'b1_1_110_100: c = 18'd244198; 8'b1_1_110_101: c = 18'd258950;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/pahb_lane.sv =====
// One allpass lane: stage state registers and a multiply/accumulate step (registered multiply, then accumulate).
module pahb_lane
    import pahb_pkg::*;
#(
    parameter int MAX_STAGES = 6,
    parameter int SAMPLE_WIDTH = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  lane_ctl_t                      ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] x_in,
    input  logic                           use_own,
    input  logic [2:0]                     tap_stage,
    output logic signed [SAMPLE_WIDTH-1:0] y_out,
    output logic                           done,
    output logic signed [SAMPLE_WIDTH-1:0] y2_tap
);

    localparam int SWL = SAMPLE_WIDTH;
    localparam int PW = SWL + 1 + CW + 1;
    localparam logic signed [SWL+1:0] HI = (SWL+2)'((64'sd1 <<< (SWL-1)) - 1);
    localparam logic signed [SWL+1:0] LO = -HI - (SWL+2)'(1);

    logic signed [SWL-1:0] xd1_reg [MAX_STAGES];
    logic signed [SWL-1:0] xd2_reg [MAX_STAGES];
    logic signed [SWL-1:0] yd1_reg [MAX_STAGES];
    logic signed [SWL-1:0] yd2_reg [MAX_STAGES];

    logic signed [SWL-1:0] x_cur_reg;
    logic signed [PW-1:0]  prod_reg;
    logic [2:0]            stg_reg;
    logic                  mul_v_reg;
    logic signed [SWL-1:0] y_reg;
    logic                  done_reg;

    logic signed [SWL-1:0] x_now;
    logic signed [SWL:0]   diff;
    logic signed [PW-1:0]  rnd;
    logic signed [SWL+1:0] ysum;
    logic signed [SWL-1:0] ysat;
    logic [$clog2(MAX_STAGES+1)-1:0] si, ti, mi;

    assign si = ctl.stage[$clog2(MAX_STAGES+1)-1:0];
    assign ti = tap_stage[$clog2(MAX_STAGES+1)-1:0];
    assign mi = stg_reg[$clog2(MAX_STAGES+1)-1:0];

    // Stage input: the external sample, zero, or the lane's last result.
    always_comb
    begin
        if (!use_own)
            x_now = ctl.zero_in ? '0 : x_in;
        else
            x_now = y_reg;
        diff = SWL'(0) + {x_now[SWL-1], x_now} - {yd2_reg[si][SWL-1], yd2_reg[si]};
        rnd = (prod_reg + (PW'(1) <<< (CW-1))) >>> CW;
        ysum = {{2{xd2_reg[mi][SWL-1]}}, xd2_reg[mi]} + rnd[SWL+1:0];
        if (ysum > HI)
            ysat = HI[SWL-1:0];
        else if (ysum < LO)
            ysat = LO[SWL-1:0];
        else
            ysat = ysum[SWL-1:0];
    end

    // Multiply stage, then accumulate, saturate and shift the stage delays.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_v_reg <= 1'b0;
            done_reg <= 1'b0;
            prod_reg <= '0;
            stg_reg <= '0;
            x_cur_reg <= '0;
            y_reg <= '0;
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                xd1_reg[i] <= '0;
                xd2_reg[i] <= '0;
                yd1_reg[i] <= '0;
                yd2_reg[i] <= '0;
            end
        end
        else
        begin
            mul_v_reg <= ctl.start;
            done_reg <= mul_v_reg;
            if (ctl.start)
            begin
                prod_reg <= PW'(diff) * $signed({1'b0, ctl.coef});
                stg_reg <= ctl.stage;
                x_cur_reg <= x_now;
            end
            if (mul_v_reg)
            begin
                y_reg <= ysat;
                xd2_reg[mi] <= xd1_reg[mi];
                xd1_reg[mi] <= x_cur_reg;
                yd2_reg[mi] <= yd1_reg[mi];
                yd1_reg[mi] <= ysat;
            end
        end
    end

    assign y_out = y_reg;
    assign done = done_reg;
    assign y2_tap = yd2_reg[ti];

endmodule

// ===== hdl/pahb_merge.sv =====
// Merging stage: rounded half sums of the A path and the delayed B path (or the B tap) with saturation.
module pahb_merge
    import pahb_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           go,
    input  logic                           use_tap,
    input  logic                           keep_b,
    input  logic                           last,
    input  logic signed [SAMPLE_WIDTH-1:0] la, lb, ra, rb, ltap, rtap,
    output logic                           res_valid,
    output logic signed [SAMPLE_WIDTH-1:0] lres, rres,
    output logic                           res_last
);

    localparam logic signed [SAMPLE_WIDTH:0] HI = (SAMPLE_WIDTH+1)'((64'sd1 <<< (SAMPLE_WIDTH-1)) - 1);
    localparam logic signed [SAMPLE_WIDTH:0] LO = -HI - (SAMPLE_WIDTH+1)'(1);

    logic signed [SAMPLE_WIDTH-1:0] dbl_reg, dbr_reg;
    logic signed [SAMPLE_WIDTH-1:0] lq, rq;

    function automatic logic signed [SAMPLE_WIDTH-1:0] hs(input logic signed [SAMPLE_WIDTH-1:0] a,
                                                       input logic signed [SAMPLE_WIDTH-1:0] b);
        logic signed [SAMPLE_WIDTH+1:0] s;
        logic signed [SAMPLE_WIDTH:0] h;
        s = (SAMPLE_WIDTH+2)'(a) + (SAMPLE_WIDTH+2)'(b) + (SAMPLE_WIDTH+2)'(1);
        h = s[SAMPLE_WIDTH+1:1];
        if (h > HI) return HI[SAMPLE_WIDTH-1:0];
        if (h < LO) return LO[SAMPLE_WIDTH-1:0];
        return h[SAMPLE_WIDTH-1:0];
    endfunction

    assign lq = hs(la, use_tap ? ltap : dbl_reg);
    assign rq = hs(ra, use_tap ? rtap : dbr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid <= 1'b0;
            dbl_reg <= '0;
            dbr_reg <= '0;
            lres <= '0;
            rres <= '0;
            res_last <= 1'b0;
        end
        else
        begin
            res_valid <= go;
            if (go)
            begin
                lres <= lq;
                rres <= rq;
                res_last <= last;
                if (!keep_b)
                begin
                    dbl_reg <= lb;
                    dbr_reg <= rb;
                end
            end
        end
    end

endmodule

// ===== hdl/polyphase_allpass_halfband_top.sv =====
// Top level: configuration, stage sequencer, four lanes, merge stage and output register.
//
// Stereo polyphase allpass half-band filter. Items enter on in_valid/in_ready as
// {left_sample, right_sample, block_last}; results leave on out_valid/out_ready as
// {left_out, right_out, run_last}. Registers are written on cfg_valid/cfg_ready
// with cfg_index 0 rate_mode, 1 steep_mode, 2 stage_count.
// Four lanes (left A, left B, right A, right B) each run the stage cascade through
// their own multiplier; each stage is issued and multiplied, accumulated, then handed
// back to the sequencer, and a run over all N stages is followed by a merge step.
// A decimate item on even phase gives no result and frees the input without a merge;
// interpolate runs the cascade twice.
// One item is in work at a time: in_ready is low from acceptance until every
// result of that item has transferred. A stalled receiver holds the output register
// and the sequencer waits for it. Reset clears all stage state, the delayed B
// samples and the decimation phase, and loads rate 0, steep 1, six stages.
module polyphase_allpass_halfband_top
    import pahb_pkg::*;
#(
    parameter int MAX_STAGES = 6
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [2:0] cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_MERGE, S_OUT} state_t;

    state_t state_reg;
    logic [1:0] rate_reg;
    logic       steep_reg;
    logic [2:0] stages_reg;
    logic [2:0] n_act;
    logic [2:0] stg_reg;
    logic       pass_reg;
    logic       phase_reg;
    logic       mode_decim, mode_interp;
    in_item_t   item_reg;
    logic       first_reg;

    lane_ctl_t ctl_a, ctl_b;
    logic signed [SW-1:0] y [4];
    logic signed [SW-1:0] t [4];
    logic d [4];
    logic go, res_v;
    logic signed [SW-1:0] lres, rres;
    logic rlast;

    assign cfg_ready = 1'b1;
    assign n_act = (stages_reg == 3'd0) ? 3'd1 :
                   (stages_reg > 3'(MAX_STAGES)) ? 3'(MAX_STAGES) : stages_reg;
    assign mode_decim = (rate_reg == RATE_DECIM);
    assign mode_interp = (rate_reg == RATE_INTERP);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        ctl_a.start = (state_reg == S_ISSUE);
        ctl_a.stage = stg_reg;
        ctl_a.zero_in = pass_reg;
        ctl_a.coef = coef_lookup(1'b0, steep_reg, n_act, stg_reg);
        ctl_b = ctl_a;
        ctl_b.coef = coef_lookup(1'b1, steep_reg, n_act, stg_reg);
    end

    // Four lanes: left A, left B, right A, right B.
    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        pahb_lane #(.MAX_STAGES(MAX_STAGES), .SAMPLE_WIDTH(SW)) u_lane (
            .clk(clk), .rst_n(rst_n),
            .ctl((k % 2 == 1) ? ctl_b : ctl_a),
            .x_in((k < 2) ? item_reg.left_sample : item_reg.right_sample),
            .use_own(!first_reg),
            .tap_stage(n_act - 3'd1),
            .y_out(y[k]), .done(d[k]), .y2_tap(t[k]));
    end

    assign go = (state_reg == S_MERGE) && !(mode_decim && !phase_reg);

    pahb_merge #(.SAMPLE_WIDTH(SW)) u_merge (
        .clk(clk), .rst_n(rst_n), .go(go),
        .use_tap(mode_decim), .keep_b(mode_decim),
        .last(!(mode_interp && !pass_reg)),
        .la(y[0]), .lb(y[1]), .ra(y[2]), .rb(y[3]), .ltap(t[1]), .rtap(t[3]),
        .res_valid(res_v), .lres(lres), .rres(rres), .res_last(rlast));

    // Sequencer, configuration registers and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rate_reg <= RATE_SAME;
            steep_reg <= 1'b1;
            stages_reg <= 3'd6;
            phase_reg <= 1'b0;
            out_valid <= 1'b0;
            out_data <= '0;
            item_reg <= '0;
            stg_reg <= '0;
            pass_reg <= 1'b0;
            first_reg <= 1'b1;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_RATE:   rate_reg <= cfg_data[1:0];
                    CFG_STEEP:  steep_reg <= cfg_data[0];
                    CFG_STAGES: stages_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg <= in_data;
                        stg_reg <= '0;
                        pass_reg <= 1'b0;
                        first_reg <= 1'b1;
                        state_reg <= S_ISSUE;
                    end
                end
                S_ISSUE: state_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (d[0])
                    begin
                        first_reg <= 1'b0;
                        if (stg_reg == n_act - 3'd1)
                            state_reg <= S_MERGE;
                        else
                        begin
                            stg_reg <= stg_reg + 3'd1;
                            state_reg <= S_ISSUE;
                        end
                    end
                end
                S_MERGE:
                begin
                    if (!go)
                    begin
                        phase_reg <= item_reg.block_last ? 1'b0 : ~phase_reg;
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res_v || (out_valid && !out_ready))
                    begin
                        if (!out_valid || out_ready)
                        begin
                            out_valid <= 1'b1;
                            out_data <= '{left_out: lres, right_out: rres, run_last: rlast};
                        end
                    end
                    if (!res_v && (!out_valid || out_ready))
                    begin
                        if (mode_interp && !pass_reg)
                        begin
                            pass_reg <= 1'b1;
                            stg_reg <= '0;
                            first_reg <= 1'b1;
                            state_reg <= S_ISSUE;
                        end
                        else
                        begin
                            if (mode_decim)
                                phase_reg <= item_reg.block_last ? 1'b0 : ~phase_reg;
                            else if (item_reg.block_last)
                                phase_reg <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Accepting a new item is never followed by a stray merge result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !res_v)
        else $error("merge result outside a run");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> !ctl_a.start)
        else $error("lane issued while waiting");
    assert property (@(posedge clk) disable iff (!rst_n)
        d[0] |-> (d[1] && d[2] && d[3]))
        else $error("lanes out of step");

endmodule

// ===== tb/sv/polyphase_allpass_halfband_checker.sv =====
// Checker for the half-band filter: watches the channels, predicts results and compares them.
module polyphase_allpass_halfband_checker
    import pahb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [2:0] cfg_data,
    output int        fail_count,
    output int        pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LANES = 4;
    localparam longint SAT_HI = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) <<< (SW - 1));

    // Shadow copy of the registers and the filter state.
    logic [1:0] rate_q;
    logic       steep_q;
    logic [2:0] stages_q;
    longint     x1 [NSTG*LANES];
    longint     x2 [NSTG*LANES];
    longint     y1 [NSTG*LANES];
    longint     y2 [NSTG*LANES];
    longint     held_b [2];
    logic       odd_phase;
    out_item_t  filtered_q [$];

    // Coefficient tables, indexed [steep][stages-1][stage].
    int unsigned tap_a [2][6][6] = '{
        '{ '{61989,0,0,0,0,0}, '{20937,142961,0,0,0,0},
           '{15807,108158,202563,0,0,0}, '{9393,71314,149961,216826,0,0},
           '{6205,49780,113134,173854,225448,0},
           '{4397,36444,87163,140945,189116,231260} },
        '{ '{61989,0,0,0,0,0}, '{31649,173854,0,0,0,0},
           '{33329,171134,240568,0,0,0}, '{20215,126372,208882,246743,0,0},
           '{13489,94316,176304,225205,250091,0},
           '{9616,71993,147089,201783,233901,252207} } };
    int unsigned tap_b [2][6][6] = '{
        '{ '{187313,0,0,0,0,0}, '{74404,218736,0,0,0,0},
           '{56616,158429,242191,0,0,0}, '{35151,111234,185150,246809,0,0},
           '{23741,80703,144599,200596,249686,0},
           '{17043,60540,114424,165927,210706,251650} },
        '{ '{187313,0,0,0,0,0}, '{102331,233514,0,0,0,0},
           '{105006,215067,255934,0,0,0}, '{69722,174353,231762,257427,0,0},
           '{48816,138924,204741,239647,258336,0},
           '{35795,110923,177613,220172,244198,258950} } };

    function automatic longint clip(longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    // Average of two samples, rounded half up, then saturated.
    function automatic longint average(longint a, longint b);
        return clip((a + b + 1) >>> 1);
    endfunction

    function automatic int live_stages();
        int n;
        n = stages_q;
        if (n < 1) n = 1;
        if (n > NSTG) n = NSTG;
        return n;
    endfunction

    // Runs one stereo sample through both allpass cascades of both channels.
    task automatic run_cascades(input longint l, input longint r, output longint lane [LANES]);
        int n;
        int i;
        longint c;
        longint y;
        n = live_stages();
        lane[0] = l; lane[1] = l; lane[2] = r; lane[3] = r;
        for (int s = 0; s < n; s++) begin
            for (int k = 0; k < LANES; k++) begin
                i = s * LANES + k;
                c = (k % 2) ? tap_b[steep_q][n-1][s] : tap_a[steep_q][n-1][s];
                y = clip(x2[i] + (((lane[k] - y2[i]) * c + (1 <<< 17)) >>> 18));
                x2[i] = x1[i]; x1[i] = lane[k];
                y2[i] = y1[i]; y1[i] = y;
                lane[k] = y;
            end
        end
    endtask

    function automatic out_item_t pack_result(longint l, longint r, logic last);
        out_item_t o;
        o.left_out = l[SW-1:0];
        o.right_out = r[SW-1:0];
        o.run_last = last;
        return o;
    endfunction

    task automatic same_rate_pass(input longint l, input longint r, input logic last);
        longint lane [LANES];
        run_cascades(l, r, lane);
        filtered_q.push_back(pack_result(average(lane[0], held_b[0]),
                                         average(lane[2], held_b[1]), last));
        held_b[0] = lane[1];
        held_b[1] = lane[3];
    endtask

    // Works out the results that one accepted sample causes.
    task automatic filter_sample(input in_item_t it);
        longint lane [LANES];
        int i;
        if (rate_q == RATE_DECIM) begin
            run_cascades(it.left_sample, it.right_sample, lane);
            if (odd_phase) begin
                i = (live_stages() - 1) * LANES;
                filtered_q.push_back(pack_result(average(lane[0], y2[i+1]),
                                                 average(lane[2], y2[i+3]), 1'b1));
            end
            odd_phase = !odd_phase;
        end else if (rate_q == RATE_INTERP) begin
            same_rate_pass(it.left_sample, it.right_sample, 1'b0);
            same_rate_pass(0, 0, 1'b1);
        end else begin
            same_rate_pass(it.left_sample, it.right_sample, 1'b1);
        end
        if (it.block_last) odd_phase = 1'b0;
    endtask

    // Predict on input and register transfers, compare on output transfers.
    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            rate_q <= RATE_SAME;
            steep_q <= 1'b1;
            stages_q <= 3'd6;
            for (int i = 0; i < NSTG*LANES; i++) begin
                x1[i] = 0; x2[i] = 0; y1[i] = 0; y2[i] = 0;
            end
            held_b[0] = 0; held_b[1] = 0;
            odd_phase = 1'b0;
            filtered_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_RATE) rate_q <= cfg_data[1:0];
                else if (cfg_index == CFG_STEEP) steep_q <= cfg_data[0];
                else if (cfg_index == CFG_STAGES) stages_q <= cfg_data;
            end
            if (in_valid && in_ready) filter_sample(in_data);
            if (out_valid && out_ready) begin
                if (filtered_q.size() == 0) begin
                    $error("unexpected result %p", out_data);
                    fail_count = fail_count + 1;
                end else begin
                    want = filtered_q.pop_front();
                    if (want.left_out !== out_data.left_out) begin
                        $error("left_out expected %0d actual %0d",
                               want.left_out, out_data.left_out);
                        fail_count = fail_count + 1;
                    end
                    if (want.right_out !== out_data.right_out) begin
                        $error("right_out expected %0d actual %0d",
                               want.right_out, out_data.right_out);
                        fail_count = fail_count + 1;
                    end
                    if (want.run_last !== out_data.run_last) begin
                        $error("run_last expected %0d actual %0d",
                               want.run_last, out_data.run_last);
                        fail_count = fail_count + 1;
                    end
                end
            end
        end
        pending_count <= filtered_q.size();
    end
endmodule

// ===== tb/sv/polyphase_allpass_halfband_top_tb.sv =====
// Testbench top: clock, reset, stimulus for samples and registers, and the verdict.
module polyphase_allpass_halfband_top_tb;
    import pahb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [2:0] cfg_data;
    int         fail_count;
    int         pending_count;
    int         cycle_count = 0;
    int         burst_left;

    polyphase_allpass_halfband_top dut (.*);
    polyphase_allpass_halfband_checker chk (.*);

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver stalls on a pattern that steps through always, mostly, half and rarely ready.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        case ((cycle_count / 64) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 1) != 0);
            default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("polyphase_allpass_halfband_top_tb NOT OK");
            $finish;
        end
    end

    // One register transfer.
    task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One sample transfer, with a random gap between bursts.
    task automatic send_sample(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r,
                               input logic last);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_data <= '{left_sample: l, right_sample: r, block_last: last};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0 || out_valid) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(SW-1){1'b1}}};
            1: return {1'b1, {(SW-1){1'b0}}};
            default: return SW'($urandom());
        endcase
    endfunction

    initial begin
        logic signed [SW-1:0] edges [4];
        edges = '{{1'b0, {(SW-1){1'b1}}}, {1'b1, {(SW-1){1'b0}}}, '0, '1};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RATE;
        cfg_data = '0;
        burst_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes under every rate mode, odd block ends, unusual and out-of-range stage counts.
        for (int m = 0; m < 4; m++) begin
            write_reg(CFG_RATE, m[2:0]);
            write_reg(CFG_STAGES, (m == 0) ? 3'd0 : (m == 3) ? 3'd7 : 3'd1 + m[2:0]);
            write_reg(CFG_STEEP, m[2:0] & 3'd1);
            for (int k = 0; k < 5; k++)
                send_sample(edges[k % 4], edges[(k + 1) % 4], k == 2);
            drain();
        end
        write_reg(2'd3, 3'd5);

        // Random phases with random settings; extremes come up through the picks.
        for (int p = 0; p < 18; p++) begin
            write_reg(CFG_RATE, 3'($urandom_range(0, 3)));
            write_reg(CFG_STEEP, 3'($urandom_range(0, 1)));
            write_reg(CFG_STAGES, (p % 3 == 0) ? 3'd6 : (p % 3 == 1) ? 3'd1
                                               : 3'($urandom_range(0, 7)));
            for (int k = 0; k < 50; k++)
                send_sample(pick_sample(), pick_sample(), $urandom_range(0, 15) == 0);
            drain();
        end

        if (fail_count == 0)
            $display("polyphase_allpass_halfband_top_tb OK");
        else
            $display("polyphase_allpass_halfband_top_tb NOT OK");
        $finish;
    end
endmodule
